@@ sv/fuzzy_max_min_centroid_macros.svh @@
// ----------------------------------------------------------------------------
// Fuzzy max-min centroid: assertion macros
// Shared property wrappers. They sample on clk_i and are disabled while
// rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef FUZZY_MAX_MIN_CENTROID_MACROS_SVH
`define FUZZY_MAX_MIN_CENTROID_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FMMC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define FMMC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/fmmc_pkg.sv @@
// ----------------------------------------------------------------------------
// Fuzzy max-min centroid: package
// Widths, class centres, the division request type and the degree clamp.
// ----------------------------------------------------------------------------
package fmmc_pkg;

  // Membership degrees.
  localparam int DEG_W = 8;
  localparam logic [15:0] DEGREE_MAX = 16'd255;

  // Output classes and their centres.
  localparam int NUM_CLASSES = 5;
  localparam int CENTRE_W = 7;
  localparam logic [CENTRE_W-1:0] CLASS_CENTRE [NUM_CLASSES] = '{
    7'd10, 7'd30, 7'd50, 7'd70, 7'd90
  };

  // Weighted sum, strength sum and quotient widths.
  localparam int NUM_W = 16;
  localparam int DEN_W = 11;
  localparam int Q_W = 7;

  // Depth of the queue between the front and the divider.
  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  typedef logic [NUM_CLASSES-1:0][DEG_W-1:0] strength_t;

  // One centroid division to be carried out.
  typedef struct packed {
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
    logic             nosup;
  } div_req_t;

  // State of one divider stage.
  typedef struct packed {
    logic [NUM_W-1:0] rem;
    logic [DEN_W-1:0] den;
    logic [Q_W-1:0]   q;
    logic             nosup;
  } div_stage_t;

  // Clamp a degree to the largest legal value.
  function automatic logic [DEG_W-1:0] sat_degree(input logic [DEG_W-1:0] d);
    logic [15:0] dx;
    dx = {{(16-DEG_W){1'b0}}, d};
    if (dx > DEGREE_MAX) begin
      return DEGREE_MAX[DEG_W-1:0];
    end
    return d;
  endfunction

endpackage

@@ sv/fmmc_if.sv @@
// ----------------------------------------------------------------------------
// Fuzzy max-min centroid: channel interfaces
// Valid/ready channels for the degree words and the result words.
// ----------------------------------------------------------------------------
interface fmmc_deg_if;
  import fmmc_pkg::*;

  logic             valid;
  logic             ready;
  logic [DEG_W-1:0] first_low;
  logic [DEG_W-1:0] first_mid;
  logic [DEG_W-1:0] first_high;
  logic [DEG_W-1:0] second_low;
  logic [DEG_W-1:0] second_mid;
  logic [DEG_W-1:0] second_high;

  modport source (
    output valid, first_low, first_mid, first_high,
    output second_low, second_mid, second_high,
    input  ready
  );
  modport sink (
    input  valid, first_low, first_mid, first_high,
    input  second_low, second_mid, second_high,
    output ready
  );
endinterface

interface fmmc_res_if;
  import fmmc_pkg::*;

  logic           valid;
  logic           ready;
  logic [Q_W-1:0] crisp_value;
  logic           no_support;

  modport source (output valid, crisp_value, no_support, input ready);
  modport sink (input valid, crisp_value, no_support, output ready);
endinterface

@@ sv/fmmc_front.sv @@
// ----------------------------------------------------------------------------
// Fuzzy max-min centroid: front end
// Two-stage pipeline: max-min class strengths, then the weighted sum and
// the strength sum that make up one division request.
// ----------------------------------------------------------------------------
`include "fuzzy_max_min_centroid_macros.svh"

module fmmc_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  fmmc_deg_if.sink           deg_i,
  output logic               req_valid_o,
  input  logic               req_ready_i,
  output fmmc_pkg::div_req_t req_o
);
  import fmmc_pkg::*;

  logic      va_q;
  logic      vb_q;
  strength_t str_q;
  strength_t str_d;
  div_req_t  req_q;
  div_req_t  req_d;
  logic      en_a;
  logic      en_b;

  // Stage advance: a stage moves when it is empty or its successor moves.
  assign en_b = !vb_q || req_ready_i;
  assign en_a = !va_q || en_b;
  assign deg_i.ready = en_a;

  // Class strengths by max-min composition.
  always_comb begin
    logic [DEG_W-1:0] f [3];
    logic [DEG_W-1:0] s [3];
    logic [DEG_W-1:0] m;
    f[0] = sat_degree(deg_i.first_low);
    f[1] = sat_degree(deg_i.first_mid);
    f[2] = sat_degree(deg_i.first_high);
    s[0] = sat_degree(deg_i.second_low);
    s[1] = sat_degree(deg_i.second_mid);
    s[2] = sat_degree(deg_i.second_high);
    str_d = '0;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        m = (f[i] < s[j]) ? f[i] : s[j];
        if (m > str_d[i+j]) begin
          str_d[i+j] = m;
        end
      end
    end
  end

  // Weighted sum and strength sum.
  always_comb begin
    req_d.num = '0;
    req_d.den = '0;
    for (int k = 0; k < NUM_CLASSES; k++) begin
      req_d.num = req_d.num + NUM_W'(str_q[k]) * NUM_W'(CLASS_CENTRE[k]);
      req_d.den = req_d.den + DEN_W'(str_q[k]);
    end
    req_d.nosup = (req_d.den == '0);
  end

  // Valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
    end else begin
      if (en_a) begin
        va_q <= deg_i.valid;
      end
      if (en_b) begin
        vb_q <= va_q;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (en_a && deg_i.valid) begin
      str_q <= str_d;
    end
    if (en_b && va_q) begin
      req_q <= req_d;
    end
  end

  assign req_valid_o = vb_q;
  assign req_o = req_q;

  // A word in the first stage moves to the second when it advances.
  `FMMC_ASSERT_NEXT(a_front_advance, va_q && en_b, vb_q,
    "front: word lost between the strength and sum stages")
  // Without support the weighted sum is zero as well.
  `FMMC_ASSERT_IMP(a_front_nosup_num, vb_q && req_q.nosup, req_q.num == '0,
    "front: nonzero weighted sum without support")

endmodule

@@ sv/fmmc_queue.sv @@
// ----------------------------------------------------------------------------
// Fuzzy max-min centroid: request queue
// Small register FIFO that decouples the front end from the divider.
// ----------------------------------------------------------------------------
`include "fuzzy_max_min_centroid_macros.svh"

module fmmc_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_valid_i,
  output logic               push_ready_o,
  input  fmmc_pkg::div_req_t push_i,
  output logic               pop_valid_o,
  input  logic               pop_ready_i,
  output fmmc_pkg::div_req_t pop_o
);
  import fmmc_pkg::*;

  div_req_t           mem_q [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_q;
  logic [Q_PTR_W-1:0] rd_ptr_q;
  logic [Q_CNT_W-1:0] cnt_q;
  logic               push;
  logic               pop;

  assign push_ready_o = (cnt_q != Q_CNT_W'(Q_DEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign push = push_valid_i && push_ready_o;
  assign pop  = pop_valid_o && pop_ready_i;
  assign pop_o = mem_q[rd_ptr_q];

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + Q_CNT_W'(1);
      end else if (pop && !push) begin
        cnt_q <= cnt_q - Q_CNT_W'(1);
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_i;
    end
  end

  // An empty queue has its pointers together.
  `FMMC_ASSERT_IMP(a_queue_empty_ptrs, cnt_q == '0, wr_ptr_q == rd_ptr_q,
    "queue: pointers apart while empty")
  // A full queue that is not drained stays full.
  `FMMC_ASSERT_NEXT(a_queue_full_hold, !push_ready_o && !pop, !push_ready_o,
    "queue: fill count changed without a pop")

endmodule

@@ sv/fmmc_divider.sv @@
// ----------------------------------------------------------------------------
// Fuzzy max-min centroid: centroid divider
// Restoring divider, one quotient bit per pipeline stage, with per-stage
// stall. The last stage is the output register.
// ----------------------------------------------------------------------------
`include "fuzzy_max_min_centroid_macros.svh"

module fmmc_divider (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               req_valid_i,
  output logic               req_ready_o,
  input  fmmc_pkg::div_req_t req_i,
  fmmc_res_if.source         res_o
);
  import fmmc_pkg::*;

  localparam int STAGES = Q_W;
  localparam int LAST = STAGES - 1;

  logic       v_q  [STAGES];
  div_stage_t st_q [STAGES];
  div_stage_t st_d [STAGES];
  logic       en   [STAGES];

  // Stall chain from the output back to the first stage.
  always_comb begin
    en[LAST] = !v_q[LAST] || res_o.ready;
    for (int s = LAST - 1; s >= 0; s--) begin
      en[s] = !v_q[s] || en[s+1];
    end
  end

  assign req_ready_o = en[0];

  // One trial subtraction per stage, most significant quotient bit first.
  always_comb begin
    div_stage_t         src;
    logic [NUM_W:0]     trial;
    logic               ge;
    for (int s = 0; s < STAGES; s++) begin
      if (s == 0) begin
        src.rem   = req_i.num;
        src.den   = req_i.den;
        src.q     = '0;
        src.nosup = req_i.nosup;
      end else begin
        src = st_q[s-1];
      end
      trial = (NUM_W+1)'(src.den) << (Q_W - 1 - s);
      ge = ({1'b0, src.rem} >= trial);
      st_d[s] = src;
      if (ge) begin
        st_d[s].rem = src.rem - trial[NUM_W-1:0];
      end
      st_d[s].q = src.q | (Q_W'(ge) << (Q_W - 1 - s));
    end
  end

  // Valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < STAGES; s++) begin
        v_q[s] <= 1'b0;
      end
    end else begin
      for (int s = 0; s < STAGES; s++) begin
        if (en[s]) begin
          v_q[s] <= (s == 0) ? req_valid_i : v_q[s-1];
        end
      end
    end
  end

  // Stage payload.
  always_ff @(posedge clk_i) begin
    for (int s = 0; s < STAGES; s++) begin
      if (en[s] && ((s == 0) ? req_valid_i : v_q[s-1])) begin
        st_q[s] <= st_d[s];
      end
    end
  end

  // Result word; without support the centroid reads as zero.
  assign res_o.valid       = v_q[LAST];
  assign res_o.crisp_value = st_q[LAST].nosup ? '0 : st_q[LAST].q;
  assign res_o.no_support  = st_q[LAST].nosup;

  // A finished division leaves a remainder below the divisor.
  `FMMC_ASSERT_IMP(a_div_rem, v_q[LAST] && !st_q[LAST].nosup,
    st_q[LAST].rem < NUM_W'(st_q[LAST].den),
    "divider: remainder not below divisor")
  // A centroid always lies between the outer class centres.
  `FMMC_ASSERT_IMP(a_div_range, v_q[LAST] && !st_q[LAST].nosup,
    (st_q[LAST].q >= CLASS_CENTRE[0]) && (st_q[LAST].q <= CLASS_CENTRE[NUM_CLASSES-1]),
    "divider: centroid outside the class centres")

endmodule

@@ sv/fuzzy_max_min_centroid.sv @@
// ----------------------------------------------------------------------------
// Fuzzy max-min centroid: top level
// Max-min inference over two three-set variables into five classes, then
// centroid defuzzification with class centres 10 to 90.
// ----------------------------------------------------------------------------
// An accepted degree word passes to its result word through 2 front stages,
// 1 queue slot and 7 divider stages, one quotient bit each.
// Throughput: one word per cycle while the result is not stalled.
// A 2-entry queue lets the front end keep accepting while the result stalls.
// Reset clears all valid bits and the queue pointers at once; no clearing pass.
module fuzzy_max_min_centroid (
  input  logic      clk_i,
  input  logic      rst_ni,
  fmmc_deg_if.sink  deg_i,
  fmmc_res_if.source res_o
);
  import fmmc_pkg::*;

  logic     front_valid;
  logic     front_ready;
  div_req_t front_req;
  logic     div_valid;
  logic     div_ready;
  div_req_t div_req;

  // Strengths and sums.
  fmmc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .deg_i       (deg_i),
    .req_valid_o (front_valid),
    .req_ready_i (front_ready),
    .req_o       (front_req)
  );

  // Decoupling queue.
  fmmc_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (front_valid),
    .push_ready_o (front_ready),
    .push_i       (front_req),
    .pop_valid_o  (div_valid),
    .pop_ready_i  (div_ready),
    .pop_o        (div_req)
  );

  // Centroid division.
  fmmc_divider u_divider (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (div_valid),
    .req_ready_o (div_ready),
    .req_i       (div_req),
    .res_o       (res_o)
  );

endmodule
